FILE: design/mac_learning_table_macros.svh
// ---------------------------------------------------------------------------
// mac learning table assertion macros
// shared assertion forms for the learning table
// ---------------------------------------------------------------------------
`ifndef MAC_LEARNING_TABLE_MACROS_SVH
`define MAC_LEARNING_TABLE_MACROS_SVH

// implication checked on every clock edge outside reset
`define MLT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define MLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/mlt_pkg.sv
// ---------------------------------------------------------------------------
// mlt_pkg
// status codes, opcodes, constants and request/response types of the mac learning table
// ---------------------------------------------------------------------------
`default_nettype none
package mlt_pkg;
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_LEARN  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_SWEEP  = 2'd3;

   localparam logic [2:0] ST_MISS      = 3'd0;
   localparam logic [2:0] ST_HIT       = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_REFRESHED = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   localparam int MAC_W     = 48;
   localparam int STAMP_W   = 32;
   localparam int REMOVED_W = 11;
   localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;
   localparam logic [31:0] HASH_MUL = 32'd11;
   localparam logic [31:0] MAX_AGE_RESET = 32'd300;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [MAC_W-1:0]  mac;
      logic [3:0]        port_in;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [3:0]           port_out;
      logic [REMOVED_W-1:0] removed;
   } rsp_type;
endpackage
`default_nettype wire

FILE: design/mlt_if.sv
// ---------------------------------------------------------------------------
// mlt channel interfaces
// valid/ready channels for request, response and register write
// ---------------------------------------------------------------------------
`default_nettype none
interface mlt_req_if import mlt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mlt_rsp_if import mlt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mlt_csr_if ();
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/mac_learning_table.sv
// ---------------------------------------------------------------------------
// mac_learning_table
// hashed set-associative mac learning table with aging sweep
// ---------------------------------------------------------------------------
// channel  dir  payload
// req      in   opcode, mac, port_in
// rsp      out  status, port_out, removed
// csr      in   max_age
//
// lookup/learn: the mac is hashed byte by byte (one shared multiply-xor), the
//   bucket modulo takes a reciprocal multiply, then a multiply-subtract, then
//   each way is read from memory and compared; an update is written in the
//   compare cycle
// tick: result the cycle after accept; sweep: every entry is visited before the result
// reset starts a clearing pass over every entry; req is not ready then
// one item at a time; req is not ready until the result is taken
// ---------------------------------------------------------------------------
`default_nettype none
`include "mac_learning_table_macros.svh"
module mac_learning_table
   import mlt_pkg::*;
#(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4,
   parameter int PORTS   = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   mlt_req_if.sink   req,
   mlt_rsp_if.source rsp,
   mlt_csr_if.sink   csr
);
   localparam int ENTRIES = BUCKETS * WAYS;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CNT_W   = IDX_W + 1;

   // reciprocal for the bucket modulo, exact for every 32-bit hash
   localparam int          DIV_L   = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
   localparam logic [63:0] DIV_NUM = 64'd1 << (32 + DIV_L);
   localparam logic [32:0] DIV_M   = 33'((DIV_NUM + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HASH  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_SWEEP = 4'd4;
   localparam logic [3:0] S_RESP  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_MOD   = 4'd7;
   localparam logic [3:0] S_CLEAR = 4'd8;

   typedef struct packed {
      logic               valid;
      logic [MAC_W-1:0]   mac;
      logic [3:0]         port;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   logic [3:0]         state_ff, state_in;
   logic [31:0]        max_age_ff, max_age_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   req_type            cur_ff, cur_in;
   logic [31:0]        hash_ff, hash_in;
   logic [31:0]        quo_ff, quo_in;
   logic [2:0]         byte_ff, byte_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BKT_W-1:0]   bkt_ff, bkt_in;
   logic               free_ok_ff, free_ok_in;
   logic [WAY_W-1:0]   free_way_ff, free_way_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rd_ok_ff, rd_ok_in;
   rsp_type            rsp_ff, rsp_in;

   entry_type          mem [ENTRIES];
   entry_type          rd_data_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   entry_type          wr_data;

   logic [7:0]         hash_byte;
   logic [31:0]        hash_mul;
   logic [64:0]        div_prod;
   logic [IDX_W-1:0]   way_idx;
   logic               match;
   logic               last_way;
   logic [STAMP_W-1:0] age;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.data  = rsp_ff;
   assign csr.ready = !reset && (state_ff == S_IDLE);

   always_comb begin
      hash_byte = cur_ff.mac[8*byte_ff +: 8];
      hash_mul  = hash_ff * HASH_MUL;
      div_prod  = 65'(hash_ff) * 65'(DIV_M);
      way_idx   = IDX_W'(cnt_ff);
      match     = rd_ok_ff && rd_data_ff.valid && (rd_data_ff.mac == cur_ff.mac);
      last_way  = (cnt_ff[WAY_W-1:0] == WAY_W'(WAYS - 1)) || (WAYS == 1);
      age       = now_ff - rd_data_ff.stamp;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx_in];
   end

   always_comb begin
      state_in    = state_ff;
      max_age_in  = max_age_ff;
      now_in      = now_ff;
      cur_in      = cur_ff;
      hash_in     = hash_ff;
      quo_in      = quo_ff;
      byte_in     = byte_ff;
      cnt_in      = cnt_ff;
      bkt_in      = bkt_ff;
      free_ok_in  = free_ok_ff;
      free_way_in = free_way_ff;
      rd_idx_in   = rd_idx_ff;
      rd_ok_in    = 1'b0;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_idx      = rd_idx_ff;
      wr_data     = rd_data_ff;
      if (csr.valid && csr.ready) begin
         max_age_in = csr.data;
      end
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            if (rd_idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               cur_in     = req.data;
               hash_in    = '0;
               byte_in    = 3'd5;
               cnt_in     = '0;
               free_ok_in = 1'b0;
               rsp_in     = '{status: ST_DONE, port_out: 4'd0, removed: '0};
               case (req.data.opcode)
                  OP_TICK: begin
                     now_in   = now_ff + 1'b1;
                     state_in = S_RESP;
                  end
                  OP_SWEEP: begin
                     rd_idx_in = '0;
                     rd_ok_in  = 1'b1;
                     state_in  = S_SWEEP;
                  end
                  default: state_in = S_HASH;
               endcase
            end
         end
         S_HASH: begin
            hash_in = {24'd0, hash_byte} ^ hash_mul;
            byte_in = byte_ff - 3'd1;
            if (byte_ff == 3'd0) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            quo_in   = 32'(div_prod >> (32 + DIV_L));
            state_in = S_MOD;
         end
         S_MOD: begin
            bkt_in   = BKT_W'(hash_ff - 32'(quo_ff * 32'(BUCKETS)));
            state_in = S_SCAN;
         end
         S_SCAN: begin
            rd_idx_in = IDX_W'(bkt_ff * WAYS) + way_idx;
            rd_ok_in  = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (!rd_data_ff.valid && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_way_in = WAY_W'(cnt_ff);
            end
            if (match) begin
               rsp_in.port_out = rd_data_ff.port;
               if (cur_ff.opcode == OP_LOOKUP) begin
                  rsp_in.status = ST_HIT;
               end else begin
                  rsp_in.status = ST_REFRESHED;
                  wr_en         = 1'b1;
                  wr_data.stamp = now_ff;
               end
               state_in = S_RESP;
            end else if (last_way) begin
               rsp_in.port_out = 4'd0;
               if (cur_ff.opcode == OP_LOOKUP || 32'(cur_ff.port_in) >= PORTS) begin
                  rsp_in.status = ST_MISS;
               end else if (free_ok_in) begin
                  rsp_in.status = ST_INSERTED;
                  wr_en         = 1'b1;
                  wr_idx        = IDX_W'(bkt_ff * WAYS) + IDX_W'(free_way_in);
                  wr_data       = '{valid: 1'b1, mac: cur_ff.mac, port: cur_ff.port_in,
                                    stamp: now_ff};
               end else begin
                  rsp_in.status = ST_FULL;
               end
               state_in = S_RESP;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SWEEP: begin
            if (rd_data_ff.valid && age >= max_age_ff) begin
               wr_en         = 1'b1;
               wr_data.valid = 1'b0;
               if (rsp_ff.removed != REMOVED_MAX) begin
                  rsp_in.removed = rsp_ff.removed + 1'b1;
               end
            end
            if (rd_idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_RESP;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
               rd_ok_in  = 1'b1;
            end
         end
         S_RESP: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         max_age_ff <= MAX_AGE_RESET;
         now_ff     <= '0;
         rd_idx_ff  <= '0;
         rd_ok_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         max_age_ff <= max_age_in;
         now_ff     <= now_in;
         rd_idx_ff  <= rd_idx_in;
         rd_ok_ff   <= rd_ok_in;
      end
      cur_ff      <= cur_in;
      hash_ff     <= hash_in;
      quo_ff      <= quo_in;
      byte_ff     <= byte_in;
      cnt_ff      <= cnt_in;
      bkt_ff      <= bkt_in;
      free_ok_ff  <= free_ok_in;
      free_way_ff <= free_way_in;
      rsp_ff      <= rsp_in;
   end

   `MLT_ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, !rsp.valid, "ready while result held")
   `MLT_ASSERT_NEXT(a_tick_now, clock, reset, req.valid && req.ready && req.data.opcode == OP_TICK, now_ff == $past(now_ff) + 1'b1, "tick did not advance time")
   `MLT_ASSERT_IMPL(a_removed_zero, clock, reset, rsp.valid && rsp.data.status != ST_DONE, rsp.data.removed == '0, "removed set on table access")
   `MLT_ASSERT_NEXT(a_sweep_keeps_now, clock, reset, state_ff == S_SWEEP, $stable(now_ff), "time moved during sweep")
endmodule
`default_nettype wire

FILE: tb/sv/mac_learning_table_test.sv
// ---------------------------------------------------------------------------
// mac_learning_table_test
// drives lookup, learn, tick and sweep items into the learning table under
// random bursts and stalls, predicts every response from a shadow table and
// compares the responses field by field; max_age is rewritten between phases
// ---------------------------------------------------------------------------
`default_nettype none
module mac_learning_table_test;
   import mlt_pkg::*;

   localparam int BUCKETS = 256;
   localparam int WAYS    = 4;
   localparam int PORTS   = 16;
   localparam int ENTRIES = BUCKETS * WAYS;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlt_req_if req ();
   mlt_rsp_if rsp ();
   mlt_csr_if csr ();

   mac_learning_table #(.BUCKETS(BUCKETS), .WAYS(WAYS), .PORTS(PORTS)) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source),
      .csr  (csr.sink)
   );

   // shadow table
   logic              tbl_valid [ENTRIES];
   logic [MAC_W-1:0]  tbl_mac   [ENTRIES];
   logic [3:0]        tbl_port  [ENTRIES];
   logic [31:0]       tbl_stamp [ENTRIES];
   logic [31:0]       tbl_now;
   logic [31:0]       age_limit;

   req_type pending_items[$];
   rsp_type expected_rsps[$];
   logic [MAC_W-1:0] mac_pool[$];

   int  errors = 0;
   int  rsp_count = 0;
   int  sweep_count = 0;
   int  full_count = 0;
   longint cycles = 0;
   bit  req_taken = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  stall_phase = 0;

   function automatic int bucket_index(logic [MAC_W-1:0] mac);
      logic [31:0] h;
      h = '0;
      for (int k = 5; k >= 0; k--)
         h = {24'd0, mac[8*k +: 8]} ^ (h * HASH_MUL);
      return int'(h % BUCKETS);
   endfunction

   function automatic rsp_type predict_rsp(req_type it);
      rsp_type r;
      int base, found;
      r = '{status: ST_DONE, port_out: 4'd0, removed: '0};
      case (it.opcode)
         OP_LOOKUP, OP_LEARN: begin
            base = bucket_index(it.mac) * WAYS;
            found = -1;
            for (int w = 0; w < WAYS; w++)
               if (found < 0 && tbl_valid[base+w] && tbl_mac[base+w] == it.mac)
                  found = base + w;
            if (found >= 0) begin
               r.port_out = tbl_port[found];
               if (it.opcode == OP_LOOKUP) begin
                  r.status = ST_HIT;
               end else begin
                  tbl_stamp[found] = tbl_now;
                  r.status = ST_REFRESHED;
               end
            end else if (it.opcode == OP_LOOKUP || int'(it.port_in) >= PORTS) begin
               r.status = ST_MISS;
            end else begin
               r.status = ST_FULL;
               for (int w = 0; w < WAYS; w++)
                  if (r.status == ST_FULL && !tbl_valid[base+w]) begin
                     tbl_valid[base+w] = 1'b1;
                     tbl_mac[base+w]   = it.mac;
                     tbl_port[base+w]  = it.port_in;
                     tbl_stamp[base+w] = tbl_now;
                     r.status = ST_INSERTED;
                  end
            end
         end
         OP_TICK: tbl_now = tbl_now + 32'd1;
         default: begin
            for (int i = 0; i < ENTRIES; i++)
               if (tbl_valid[i] && (tbl_now - tbl_stamp[i]) >= age_limit) begin
                  tbl_valid[i] = 1'b0;
                  if (r.removed != REMOVED_MAX) r.removed++;
               end
         end
      endcase
      return r;
   endfunction

   task automatic add_item(logic [1:0] op, logic [MAC_W-1:0] mac, logic [3:0] port);
      pending_items.push_back('{opcode: op, mac: mac, port_in: port});
   endtask

   function automatic logic [MAC_W-1:0] random_mac();
      return MAC_W'({$urandom, $urandom});
   endfunction

   // addresses that share one bucket, to fill it past WAYS
   task automatic add_bucket_flood(int n);
      logic [MAC_W-1:0] m, first;
      int b;
      first = random_mac();
      b = bucket_index(first);
      add_item(OP_LEARN, first, 4'($urandom));
      mac_pool.push_back(first);
      for (int k = 1; k < n; k++) begin
         do m = random_mac(); while (bucket_index(m) != b);
         add_item(OP_LEARN, m, 4'($urandom));
         mac_pool.push_back(m);
      end
   endtask

   task automatic wait_drained(int extra);
      while (pending_items.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_max_age(logic [31:0] v);
      @(negedge clock);
      csr.data  <= v;
      csr.valid <= 1'b1;
      @(posedge clock);
      while (!(csr.valid && csr.ready)) @(posedge clock);
      age_limit = v;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   initial begin
      forever #4 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!(req.valid && !req_taken)) begin
         if (req_taken) void'(pending_items.pop_front());
         if (gap_left > 0) begin
            gap_left--;
            req.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req.valid <= 1'b1;
            req.data  <= pending_items[0];
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 64;
      if (reset) rsp.ready <= 1'b0;
      else if (stall_phase < 20) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, 2) != 0);
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      req_taken = !reset && req.valid && req.ready;
      if (req_taken)
         expected_rsps.push_back(predict_rsp(req.data));
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected item status=%0d port=%0d removed=%0d", $time,
                     rsp.data.status, rsp.data.port_out, rsp.data.removed);
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (e.status == ST_FULL) full_count++;
            if (e.status == ST_DONE && e.removed != 0) sweep_count++;
            if (rsp.data.status !== e.status || rsp.data.port_out !== e.port_out ||
                rsp.data.removed !== e.removed) begin
               errors++;
               $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                        e.status, e.port_out, e.removed, rsp.data.status,
                        rsp.data.port_out, rsp.data.removed);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("mac_learning_table_test: FAIL");
         $finish;
      end
   end

   initial begin
      logic [MAC_W-1:0] m;
      int r;
      req.valid = 1'b0;
      req.data  = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.data  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_mac[i] = '0;
         tbl_port[i] = '0;
         tbl_stamp[i] = '0;
      end
      tbl_now = '0;
      age_limit = MAX_AGE_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      add_item(OP_LOOKUP, '0, 4'd0);
      add_item(OP_LEARN, '0, 4'd0);
      add_item(OP_LEARN, '1, 4'd15);
      add_item(OP_LOOKUP, '1, 4'd3);
      add_item(OP_LEARN, '0, 4'd9);
      add_item(OP_LOOKUP, '0, 4'd0);
      add_item(OP_TICK, '1, 4'd15);
      add_item(OP_SWEEP, '1, 4'd15);
      add_bucket_flood(WAYS + 2);
      add_item(OP_LOOKUP, 48'h0123_4567_89ab, 4'd1);
      add_item(OP_LEARN, 48'hfedc_ba98_7654, 4'd7);
      add_item(OP_TICK, '0, 4'd0);
      add_item(OP_LEARN, 48'hfedc_ba98_7654, 4'd2);
      wait_drained(1100);

      write_max_age(32'd1);
      add_item(OP_TICK, '0, 4'd0);
      add_item(OP_SWEEP, '0, 4'd0);
      add_item(OP_LOOKUP, 48'hfedc_ba98_7654, 4'd0);
      wait_drained(1100);
      write_max_age(32'd0);
      add_item(OP_LEARN, 48'h1111_2222_3333, 4'd4);
      add_item(OP_SWEEP, '0, 4'd0);
      wait_drained(1100);
      write_max_age(32'hffff_ffff);

      // random phases
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 2) write_max_age(32'd1 + $urandom_range(0, 3));
         else if (phase == 3) write_max_age(32'd8 + $urandom_range(0, 30));
         else if (phase == 4) write_max_age(MAX_AGE_RESET);
         for (int n = 0; n < 140; n++) begin
            r = $urandom_range(0, 99);
            if (mac_pool.size() != 0 && r < 35) m = mac_pool[$urandom_range(0, mac_pool.size()-1)];
            else m = random_mac();
            if (r < 30) add_item(OP_LOOKUP, m, 4'($urandom));
            else if (r < 78) begin
               add_item(OP_LEARN, m, 4'($urandom));
               if (mac_pool.size() < 200) mac_pool.push_back(m);
            end else if (r < 93) add_item(OP_TICK, random_mac(), 4'($urandom));
            else if (r < 97) add_item(OP_SWEEP, random_mac(), 4'($urandom));
            else add_bucket_flood(WAYS + 1);
            if (n == 75 && phase == 1) begin
               wait_drained(3);
            end
         end
         wait_drained(1100);
      end

      $display("covered %0d responses: %0d non-empty sweeps, %0d bucket-full learns",
               rsp_count, sweep_count, full_count);
      $display("max_age settings 300, 1, 0, 2^32-1 and random small values");
      if (errors == 0) $display("mac_learning_table_test: PASS");
      else $display("mac_learning_table_test: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
